FILE: rtl/lwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lockable watchdog timer package
// Shared types, register offsets, codes and constants of the watchdog core.
// ----------------------------------------------------------------------------
package lwt_pkg;

    // The watchdog clock runs at 2^TPS_BITS ticks per second.
    localparam int TPS_BITS         = 15;
    localparam int TICKS_PER_SECOND = 1 << TPS_BITS;
    localparam int CNT_W            = 33;

    // Item kinds on the input side.
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Register byte offsets.
    localparam logic [11:0] OFS_LOAD   = 12'h000;
    localparam logic [11:0] OFS_VALUE  = 12'h004;
    localparam logic [11:0] OFS_CTRL   = 12'h008;
    localparam logic [11:0] OFS_INTCLR = 12'h00c;
    localparam logic [11:0] OFS_RIS    = 12'h010;
    localparam logic [11:0] OFS_MIS    = 12'h014;
    localparam logic [11:0] OFS_LOCK   = 12'hc00;
    localparam logic [11:0] OFS_PID0   = 12'hfe0;
    localparam logic [11:0] OFS_PID1   = 12'hfe4;
    localparam logic [11:0] OFS_PID2   = 12'hfe8;
    localparam logic [11:0] OFS_PID3   = 12'hfec;
    localparam logic [11:0] OFS_CID0   = 12'hff0;
    localparam logic [11:0] OFS_CID1   = 12'hff4;
    localparam logic [11:0] OFS_CID2   = 12'hff8;
    localparam logic [11:0] OFS_CID3   = 12'hffc;

    // Identification register contents.
    localparam logic [31:0] PID0_VAL = 32'h05;
    localparam logic [31:0] PID1_VAL = (32'h1 << 4) | 32'h8;
    localparam logic [31:0] PID2_VAL = (32'h1 << 4) | 32'h4;
    localparam logic [31:0] PID3_VAL = 32'h00;
    localparam logic [31:0] CID0_VAL = 32'h0d;
    localparam logic [31:0] CID1_VAL = 32'hf0;
    localparam logic [31:0] CID2_VAL = 32'h05;
    localparam logic [31:0] CID3_VAL = 32'hb1;

    // Lock register keys.
    localparam logic [31:0] KEY_UNLOCK = 32'h1acce551;
    localparam logic [31:0] KEY_LOCK   = 32'h00000001;

    typedef struct packed {
        logic [31:0] write_data;
        logic [11:0] offset;
        logic [1:0]  mode;
    } t_item;

    typedef struct packed {
        logic        reset_request;
        logic        irq_raise;
        logic        write_refused;
        logic [31:0] read_data;
    } t_result;

endpackage

FILE: rtl/lwt_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchdog engine
// Holds the watchdog state and works out the result of one item per cycle while i_fire is high.
// ----------------------------------------------------------------------------
module lwt_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  lwt_pkg::t_item   i_item,
    output lwt_pkg::t_result o_result
);
    import lwt_pkg::*;

    logic             r_irq_enable, n_irq_enable;
    logic             r_reset_enable, n_reset_enable;
    logic             r_irq_pending, n_irq_pending;
    logic             r_locked, n_locked;
    logic [CNT_W-1:0] r_reload, n_reload;
    logic [CNT_W-1:0] r_remaining, n_remaining;
    logic             r_counting, n_counting;

    logic [CNT_W-1:0] load_sum;
    logic [CNT_W-1:0] load_rounded;
    logic [CNT_W-1:0] value_floor;
    logic [31:0]      value_rd;
    logic [31:0]      read_mux;

    // Round the load value up to whole seconds; the add cannot leave 33 bits.
    assign load_sum     = {1'b0, i_item.write_data}
                        + {{(CNT_W-TPS_BITS){1'b0}}, {TPS_BITS{1'b1}}};
    assign load_rounded = {load_sum[CNT_W-1:TPS_BITS], {TPS_BITS{1'b0}}};
    assign value_floor  = {r_remaining[CNT_W-1:TPS_BITS], {TPS_BITS{1'b0}}};
    assign value_rd     = !r_counting ? 32'd0 :
                          (value_floor[CNT_W-1] ? 32'hffffffff : value_floor[31:0]);

    always_comb begin
        unique case (i_item.offset)
            OFS_VALUE: read_mux = value_rd;
            OFS_CTRL:  read_mux = {30'd0, r_reset_enable, r_irq_enable};
            OFS_RIS:   read_mux = {31'd0, r_irq_pending};
            OFS_MIS:   read_mux = {31'd0, r_irq_pending & r_irq_enable};
            OFS_LOCK:  read_mux = {31'd0, r_locked};
            OFS_PID0:  read_mux = PID0_VAL;
            OFS_PID1:  read_mux = PID1_VAL;
            OFS_PID2:  read_mux = PID2_VAL;
            OFS_PID3:  read_mux = PID3_VAL;
            OFS_CID0:  read_mux = CID0_VAL;
            OFS_CID1:  read_mux = CID1_VAL;
            OFS_CID2:  read_mux = CID2_VAL;
            OFS_CID3:  read_mux = CID3_VAL;
            default:   read_mux = 32'd0;
        endcase
    end

    always_comb begin
        n_irq_enable   = r_irq_enable;
        n_reset_enable = r_reset_enable;
        n_irq_pending  = r_irq_pending;
        n_locked       = r_locked;
        n_reload       = r_reload;
        n_remaining    = r_remaining;
        n_counting     = r_counting;
        o_result       = '0;

        unique case (i_item.mode)
            MODE_READ: begin
                o_result.read_data = read_mux;
            end
            MODE_WRITE: begin
                if (i_item.offset != OFS_LOCK && r_locked) begin
                    o_result.write_refused = 1'b1;
                end else begin
                    unique case (i_item.offset)
                        OFS_LOAD: begin
                            n_reload = load_rounded;
                        end
                        OFS_CTRL: begin
                            if (i_item.write_data[0] != r_irq_enable) begin
                                n_irq_enable = i_item.write_data[0];
                                if (i_item.write_data[0]) begin
                                    n_remaining = r_reload;
                                    n_counting  = 1'b1;
                                end else begin
                                    n_irq_pending = 1'b0;
                                    n_counting    = 1'b0;
                                end
                            end
                            n_reset_enable = i_item.write_data[1];
                        end
                        OFS_INTCLR: begin
                            n_irq_pending = 1'b0;
                            if (r_irq_enable) begin
                                n_remaining = r_reload;
                                n_counting  = 1'b1;
                            end
                        end
                        OFS_LOCK: begin
                            if (i_item.write_data == KEY_UNLOCK) begin
                                n_locked = 1'b0;
                            end else if (i_item.write_data == KEY_LOCK) begin
                                n_locked = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            MODE_TICK: begin
                if (r_counting) begin
                    // A count of one or zero expires on this tick.
                    if (|r_remaining[CNT_W-1:1]) begin
                        n_remaining = r_remaining - CNT_W'(1);
                    end else if (r_irq_pending && r_reset_enable) begin
                        o_result.reset_request = 1'b1;
                        n_counting             = 1'b0;
                        n_remaining            = '0;
                    end else if (r_irq_enable) begin
                        o_result.irq_raise = 1'b1;
                        n_irq_pending      = 1'b1;
                        n_remaining        = r_reload;
                    end else begin
                        n_counting  = 1'b0;
                        n_remaining = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_enable   <= 1'b0;
            r_reset_enable <= 1'b0;
            r_irq_pending  <= 1'b0;
            r_locked       <= 1'b1;
            r_reload       <= '0;
            r_remaining    <= '0;
            r_counting     <= 1'b0;
        end else if (i_fire) begin
            r_irq_enable   <= n_irq_enable;
            r_reset_enable <= n_reset_enable;
            r_irq_pending  <= n_irq_pending;
            r_locked       <= n_locked;
            r_reload       <= n_reload;
            r_remaining    <= n_remaining;
            r_counting     <= n_counting;
        end
    end

    a_reset_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.reset_request) |=> (!r_counting && r_irq_pending))
        else $error("reset request did not stop the countdown");

    a_irq_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.irq_raise) |=> (r_irq_pending && r_counting))
        else $error("raised interrupt is not pending");

    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_result.irq_raise && o_result.reset_request))
        else $error("interrupt and reset request in the same item");

    a_locked_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.write_refused) |=> ($stable(r_reload) && r_locked))
        else $error("refused write changed state");

endmodule

FILE: rtl/lockable_watchdog_timer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lockable watchdog timer core
// Register-mapped watchdog with lock key, stream access and one result per item.
// ----------------------------------------------------------------------------
// Path: an accepted input is held in the input register, then the engine state
// update and the result register take effect on the same edge.
// Throughput: one item per cycle; the only stall is back-pressure on the output.
// Reset: synchronous, active low; clears valids and all watchdog state, and
// leaves the register window locked.
module lockable_watchdog_timer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [11:0] offset, [43:12] write_data, rest zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [31:0] read_data, [32] write_refused,
                                          // [33] irq_raise, [34] reset_request, rest zero
);
    import lwt_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_result;
    t_result eng_result;
    logic    advance;

    // The result register frees up when empty or taken this cycle.
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_item.mode       <= i_s_axis_tuser;
            r_in_item.offset     <= i_s_axis_tdata[11:0];
            r_in_item.write_data <= i_s_axis_tdata[43:12];
        end
    end

    lwt_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (r_in_valid && advance),
        .i_item   (r_in_item),
        .o_result (eng_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_result <= eng_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_result};

endmodule
